### hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared constants for the point-in-polygon crossing test
// Default coordinate width and the minimum vertex count of a real polygon.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    localparam int COORD_BITS_DEFAULT = 16;

    // vertex counter is two bits wide and saturates here
    localparam logic [1:0] MIN_VERTICES = 2'd3;

endpackage

`default_nettype wire

### hdl/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core: even-odd crossing test, one vertex per request
// Input requests carry one polygon vertex plus first/last marks; the query
// point is sampled with the first vertex. A request marked last closes the
// polygon back to its first vertex and produces one result request with
// m_point_inside and m_too_few_vertices (fewer than three vertices).
// Both channels use valid/ready. s_ready is high while the sequencer is idle.
// Each edge is handled in a setup state. An edge that spans the query point in
// both x and y and not settled by signs is decided by a bit-serial multiply
// (two shift-add accumulators side by side) and a compare state. A request is
// accepted in the idle state; a non-first one runs the edge from the previous
// vertex, one marked last closes the polygon and posts the result. The result
// sits in an output register; the core takes the next vertex while it waits,
// and only stalls before posting a new result until the previous one is taken.
// Reset clears the query point, start and previous vertex to zero, the parity
// and the vertex count, and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_core #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_query_x,
    input  wire logic signed [COORD_BITS-1:0] s_query_y,
    input  wire logic signed [COORD_BITS-1:0] s_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] s_vertex_y,
    input  wire logic                         s_first_vertex,
    input  wire logic                         s_last_vertex,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_point_inside,
    output logic                              m_too_few_vertices
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = $clog2(DW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_CMP,
        S_POST
    } state_t;

    state_t state_reg;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic signed [COORD_BITS-1:0] sx_reg, sy_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] ex0_reg, ey0_reg, ex1_reg, ey1_reg;
    logic                         parity_reg;
    logic [1:0]                   count_reg;
    logic                         last_reg;
    logic                         second_reg;
    logic                         neg_reg;
    logic [DW-1:0]                ma_reg, mb_reg, md_reg, mk_reg;
    logic [PW-1:0]                p_acc_reg, r_acc_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         m_valid_reg;
    logic                         m_inside_reg;
    logic                         m_few_reg;

    // setup decode of the current edge
    logic signed [DW-1:0] a_diff, b_diff, d_diff, t_diff;
    logic                 yf0, yf1, xf0, xf1;
    logic                 setup_neg;
    logic                 setup_resolved;
    logic                 setup_toggle;
    logic [DW-1:0]        setup_k;
    logic                 edge_done;
    logic                 edge_toggle;
    logic [DW:0]          p_sum, r_sum;
    logic                 accept;

    assign accept = s_valid && (state_reg == S_IDLE);

    always_comb begin
        a_diff = {ey1_reg[COORD_BITS-1], ey1_reg} - {qy_reg[COORD_BITS-1], qy_reg};
        b_diff = {ex0_reg[COORD_BITS-1], ex0_reg} - {ex1_reg[COORD_BITS-1], ex1_reg};
        d_diff = {ey0_reg[COORD_BITS-1], ey0_reg} - {ey1_reg[COORD_BITS-1], ey1_reg};
        t_diff = {ex1_reg[COORD_BITS-1], ex1_reg} - {qx_reg[COORD_BITS-1], qx_reg};
        yf0 = (ey0_reg >= qy_reg);
        yf1 = (ey1_reg >= qy_reg);
        xf0 = (ex0_reg >= qx_reg);
        xf1 = (ex1_reg >= qx_reg);
        setup_neg = a_diff[DW-1] ^ b_diff[DW-1] ^ d_diff[DW-1];
        setup_k = setup_neg ? DW'(-t_diff) : DW'(t_diff + DW'(1));
        setup_resolved = 1'b1;
        setup_toggle = 1'b0;
        if (yf0 == yf1) begin
            setup_toggle = 1'b0;
        end else if (xf0 == xf1) begin
            setup_toggle = xf0;
        end else if (setup_neg) begin
            // -floor(P/D) <= t holds for any t >= 0
            setup_toggle = 1'b1;
            setup_resolved = !t_diff[DW-1];
        end else begin
            // floor(P/D) <= t cannot hold for t < 0
            setup_toggle = 1'b0;
            setup_resolved = t_diff[DW-1];
        end
    end

    always_comb begin
        edge_done = 1'b0;
        edge_toggle = 1'b0;
        case (state_reg)
            S_SETUP: begin
                edge_done = setup_resolved;
                edge_toggle = setup_toggle;
            end
            S_CMP: begin
                edge_done = 1'b1;
                edge_toggle = neg_reg ? (p_acc_reg >= r_acc_reg) : (p_acc_reg < r_acc_reg);
            end
            default: begin
                edge_done = 1'b0;
                edge_toggle = 1'b0;
            end
        endcase
    end

    // shift-add steps: upper half plus addend, then shift right one bit
    assign p_sum = {1'b0, p_acc_reg[PW-1:DW]} + (mb_reg[0] ? {1'b0, ma_reg} : '0);
    assign r_sum = {1'b0, r_acc_reg[PW-1:DW]} + (mk_reg[0] ? {1'b0, md_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            qx_reg       <= '0;
            qy_reg       <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            parity_reg   <= 1'b0;
            count_reg    <= '0;
            last_reg     <= 1'b0;
            second_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_inside_reg <= 1'b0;
            m_few_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_POST)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        px_reg   <= s_vertex_x;
                        py_reg   <= s_vertex_y;
                        last_reg <= s_last_vertex;
                        if (s_first_vertex) begin
                            qx_reg     <= s_query_x;
                            qy_reg     <= s_query_y;
                            sx_reg     <= s_vertex_x;
                            sy_reg     <= s_vertex_y;
                            parity_reg <= 1'b0;
                            count_reg  <= 2'd1;
                            second_reg <= 1'b0;
                            // closing edge of a lone vertex never crosses
                            state_reg  <= s_last_vertex ? S_POST : S_IDLE;
                        end else begin
                            if (count_reg < MIN_VERTICES) begin
                                count_reg <= count_reg + 2'd1;
                            end
                            ex0_reg    <= px_reg;
                            ey0_reg    <= py_reg;
                            ex1_reg    <= s_vertex_x;
                            ey1_reg    <= s_vertex_y;
                            second_reg <= s_last_vertex;
                            state_reg  <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    if (!setup_resolved) begin
                        neg_reg   <= setup_neg;
                        ma_reg    <= a_diff[DW-1] ? DW'(-a_diff) : DW'(a_diff);
                        mb_reg    <= b_diff[DW-1] ? DW'(-b_diff) : DW'(b_diff);
                        md_reg    <= d_diff[DW-1] ? DW'(-d_diff) : DW'(d_diff);
                        mk_reg    <= setup_k;
                        p_acc_reg <= '0;
                        r_acc_reg <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    p_acc_reg <= {p_sum, p_acc_reg[DW-1:1]};
                    r_acc_reg <= {r_sum, r_acc_reg[DW-1:1]};
                    mb_reg    <= mb_reg >> 1;
                    mk_reg    <= mk_reg >> 1;
                    cnt_reg   <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(DW - 1)) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                end
                S_POST: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_few_reg    <= (count_reg < MIN_VERTICES);
                        m_inside_reg <= (count_reg < MIN_VERTICES) ? 1'b0 : parity_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (edge_done) begin
                parity_reg <= parity_reg ^ edge_toggle;
                if (second_reg) begin
                    // closing edge: current vertex back to the first one
                    ex0_reg    <= px_reg;
                    ey0_reg    <= py_reg;
                    ex1_reg    <= sx_reg;
                    ey1_reg    <= sy_reg;
                    second_reg <= 1'b0;
                    state_reg  <= S_SETUP;
                end else begin
                    state_reg <= last_reg ? S_POST : S_IDLE;
                end
            end
        end
    end

    assign s_ready            = (state_reg == S_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_point_inside     = m_inside_reg;
    assign m_too_few_vertices = m_few_reg;

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for point_in_polygon_test_core
// Drives polygon vertex requests through the input channel and predicts each
// even-odd result with a local crossing-test model. Directed polygons cover
// coordinate extremes, degenerate and unmarked runs. Random polygons follow
// under five sender/receiver idle mixes, with one full drain pause.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW = pip_pkg::COORD_BITS_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 2 * CW + 16;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic in_poly;
        logic too_few;
    } verdict_t;

    localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    coord_t s_query_x;
    coord_t s_query_y;
    coord_t s_vertex_x;
    coord_t s_vertex_y;
    logic   s_first_vertex;
    logic   s_last_vertex;
    logic   m_valid;
    logic   m_ready;
    logic   m_point_inside;
    logic   m_too_few_vertices;

    point_in_polygon_test_core #(
        .COORD_BITS(CW)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_query_x         (s_query_x),
        .s_query_y         (s_query_y),
        .s_vertex_x        (s_vertex_x),
        .s_vertex_y        (s_vertex_y),
        .s_first_vertex    (s_first_vertex),
        .s_last_vertex     (s_last_vertex),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_point_inside    (m_point_inside),
        .m_too_few_vertices(m_too_few_vertices)
    );

    verdict_t    expected_verdicts[$];
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_cycles = 0;

    // polygon tracker state
    longint      probe_x = 0;
    longint      probe_y = 0;
    longint      anchor_x = 0;
    longint      anchor_y = 0;
    longint      trail_x = 0;
    longint      trail_y = 0;
    bit          crossings_odd = 0;
    logic [1:0]  corner_count = 2'd0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit edge_toggles(longint x0, longint y0, longint x1, longint y1);
        bit     yf0;
        bit     yf1;
        bit     xf0;
        bit     xf1;
        longint a;
        longint b;
        longint d;
        longint q;
        yf0 = y0 >= probe_y;
        yf1 = y1 >= probe_y;
        if (yf0 == yf1) begin
            return 1'b0;
        end
        xf0 = x0 >= probe_x;
        xf1 = x1 >= probe_x;
        if (xf0 == xf1) begin
            return xf0;
        end
        a = y1 - probe_y;
        b = x0 - x1;
        d = y0 - y1;
        q = (a * b) / d;
        return (x1 - q) >= probe_x;
    endfunction

    task automatic fold_vertex(input coord_t qx, input coord_t qy, input coord_t vx,
                               input coord_t vy, input bit first, input bit last);
        verdict_t v;
        if (first) begin
            probe_x = qx;
            probe_y = qy;
            anchor_x = vx;
            anchor_y = vy;
            crossings_odd = 1'b0;
            corner_count = 2'd1;
        end else begin
            crossings_odd ^= edge_toggles(trail_x, trail_y, vx, vy);
            if (corner_count < pip_pkg::MIN_VERTICES) begin
                corner_count++;
            end
        end
        trail_x = vx;
        trail_y = vy;
        if (last) begin
            crossings_odd ^= edge_toggles(vx, vy, anchor_x, anchor_y);
            if (corner_count < pip_pkg::MIN_VERTICES) begin
                v.in_poly = 1'b0;
                v.too_few = 1'b1;
            end else begin
                v.in_poly = crossings_odd;
                v.too_few = 1'b0;
            end
            expected_verdicts.push_back(v);
        end
    endtask

    // prediction on each accepted request, then result check
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                fold_vertex(s_query_x, s_query_y, s_vertex_x, s_vertex_y,
                            s_first_vertex, s_last_vertex);
            end
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, actual inside=%0b too_few=%0b",
                             $time, m_point_inside, m_too_few_vertices);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_point_inside !== want.in_poly) begin
                        error_count++;
                        $display("%0t: point_inside expected %0b actual %0b",
                                 $time, want.in_poly, m_point_inside);
                    end
                    if (m_too_few_vertices !== want.too_few) begin
                        error_count++;
                        $display("%0t: too_few_vertices expected %0b actual %0b",
                                 $time, want.too_few, m_too_few_vertices);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_vertex(input coord_t qx, input coord_t qy, input coord_t vx,
                               input coord_t vy, input bit first, input bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_query_x <= qx;
        s_query_y <= qy;
        s_vertex_x <= vx;
        s_vertex_y <= vy;
        s_first_vertex <= first;
        s_last_vertex <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic coord_t pick_coord(coord_t around);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 5) begin
            return $urandom_range(1) ? COORD_MAX : COORD_MIN;
        end else if (sel < 35) begin
            return coord_t'($urandom);
        end else if (sel < 50) begin
            return coord_t'(int'(around) + int'($urandom_range(4)) - 2);
        end
        return coord_t'(int'(around) + int'($urandom_range(512)) - 256);
    endfunction

    // vertices with no first mark continue from the cleared reset state
    task automatic test_reset_state_carry();
        send_vertex(0, 0, 100, -50, 1'b0, 1'b0);
        send_vertex(0, 0, -100, 50, 1'b0, 1'b1);
        send_vertex(0, 0, 200, 300, 1'b0, 1'b1);
    endtask

    task automatic test_degenerate_polygons();
        send_vertex(5, 5, 5, 5, 1'b1, 1'b1);
        send_vertex(-7, 3, 10, -10, 1'b1, 1'b0);
        send_vertex(0, 0, -10, 10, 1'b0, 1'b1);
    endtask

    task automatic test_extreme_coords();
        send_vertex(0, 0, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(0, 0, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_vertex(0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_vertex(0, 0, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        send_vertex(0, 0, COORD_MAX, 0, 1'b0, 1'b0);
        send_vertex(0, 0, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
        // sloped edges straddling the query in x and y
        send_vertex(0, 0, -30, -20, 1'b1, 1'b0);
        send_vertex(0, 0, 40, 25, 1'b0, 1'b0);
        send_vertex(0, 0, -35, 18, 1'b0, 1'b1);
        // vertex lying on the query row
        send_vertex(3, 7, 0, 7, 1'b1, 1'b0);
        send_vertex(3, 7, 10, 0, 1'b0, 1'b0);
        send_vertex(3, 7, 10, 14, 1'b0, 1'b1);
    endtask

    // a run that goes on past its last mark keeps accumulating
    task automatic test_unterminated_runs();
        send_vertex(9, 9, 20, 20, 1'b0, 1'b0);
        send_vertex(-9, -9, -20, 20, 1'b0, 1'b1);
    endtask

    task automatic test_random_polygons(input int unsigned count, input int unsigned tx_idle,
                                        input int unsigned rx_idle);
        int unsigned sent;
        int unsigned sides;
        bit          noisy;
        bit          first;
        bit          last;
        coord_t      qx;
        coord_t      qy;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        sent = 0;
        while (sent < count) begin
            sides = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(7, 1);
            noisy = ($urandom_range(99) < 15);
            qx = pick_coord(coord_t'($urandom));
            qy = pick_coord(coord_t'($urandom));
            for (int unsigned i = 0; i < sides; i++) begin
                if (noisy) begin
                    first = ($urandom_range(3) == 0);
                    last = ($urandom_range(2) == 0);
                end else begin
                    first = (i == 0);
                    last = (i == sides - 1);
                end
                if (first) begin
                    send_vertex(qx, qy, pick_coord(qx), pick_coord(qy), first, last);
                end else begin
                    send_vertex(coord_t'($urandom), coord_t'($urandom),
                                pick_coord(qx), pick_coord(qy), first, last);
                end
            end
            sent += sides;
        end
    endtask

    task automatic test_drain_pause();
        test_random_polygons(12, 0, 50);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        test_random_polygons(12, 10, 10);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_query_x <= '0;
        s_query_y <= '0;
        s_vertex_x <= '0;
        s_vertex_y <= '0;
        s_first_vertex <= 1'b0;
        s_last_vertex <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 73;
        test_reset_state_carry();
        test_degenerate_polygons();
        test_extreme_coords();
        test_unterminated_runs();
        test_random_polygons(570, 29, 73);
        test_drain_pause();
        test_random_polygons(570, 73, 29);
        test_random_polygons(570, 0, 0);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if ((error_count == 0) && (expected_verdicts.size() == 0)) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
